/* rtl/core/mbdp_pkg.sv */
// ----------------------------------------------------------------------------
// mbdp_pkg
// Shared constants and types for the memory-mapped disk port.
// ----------------------------------------------------------------------------
package mbdp_pkg;

    localparam int DISK_BYTES_DEF = 65536;

    localparam int DATA_W     = 64;
    localparam int OFF_W      = 5;
    localparam int POS_W      = 17;
    localparam int CAP_W      = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int WORD_BYTES = 8;

    localparam logic [OFF_W-1:0] OFF_POSITION = 5'd0;
    localparam logic [OFF_W-1:0] OFF_DATA     = 5'd8;
    localparam logic [OFF_W-1:0] OFF_CAPACITY = 5'd16;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 4'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

    typedef struct packed {
        logic start;
        logic is_write;
    } t_xfer_cmd;

    typedef struct packed {
        logic clearing;
        logic done;
    } t_xfer_sts;

endpackage

/* rtl/core/mmio_block_disk_port.sv */
// ----------------------------------------------------------------------------
// mmio_block_disk_port
// Memory-mapped virtual disk: position, data window and capacity registers.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid / o_in_stall with i_req_type, i_reg_offset and
// i_write_value; each request yields one response on o_out_valid /
// i_out_stall with o_read_data and o_access_ok. Configuration (capacity,
// disk present) is written on i_cfg_valid / o_cfg_ready, index and data.
// Responses: position, capacity, rejected and failed requests are answered
// from the output register, or the buffer behind it while the output stalls.
// A data window write or read moves eight bytes through the byte-wide store
// one per cycle; a read also passes through the registered read of the store.
// Throughput: one request at a time; a new request is taken while the last
// response waits, and one more response is buffered behind it.
// Reset: position clears, capacity returns to 65536, disk present to 1, and
// the store is swept to zeros one byte per cycle over all DISK_BYTES bytes,
// while o_in_stall stays high. Config writes are taken during the sweep.
// A stalled response holds; the block stalls input once its buffer is full.
// ----------------------------------------------------------------------------
module mmio_block_disk_port #(
    parameter int DISK_BYTES = mbdp_pkg::DISK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [mbdp_pkg::OFF_W-1:0]      i_reg_offset,
    input  logic [mbdp_pkg::DATA_W-1:0]     i_write_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mbdp_pkg::DATA_W-1:0]     o_read_data,
    output logic                            o_access_ok,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbdp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbdp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbdp_pkg::*;

    localparam int AW    = $clog2(DISK_BYTES);
    localparam int XW    = (AW > POS_W) ? AW : POS_W;
    localparam int DW    = $clog2(DISK_BYTES + 1);
    localparam int MW    = (DW > CAP_W) ? DW : CAP_W;
    localparam logic [MW-1:0] DISK_EXT = MW'(DISK_BYTES);

    logic [CAP_W-1:0]  r_cap;
    logic              r_present;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_busy;
    logic              r_job_rd;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_ok;
    logic              r_pend_valid;
    logic [DATA_W-1:0] r_pend_data;
    logic              r_pend_ok;

    t_xfer_cmd         xfer_cmd;
    t_xfer_sts         xfer_sts;
    logic [DATA_W-1:0] xfer_rdata;
    logic [XW-1:0]     pos_ext;
    logic [AW-1:0]     xfer_addr;

    logic [MW-1:0]     cap_ext;
    logic [CAP_W-1:0]  cap_eff;
    logic [POS_W:0]    pos_plus8;
    logic              data_ok;
    logic              accept;
    logic              out_free;
    logic              res_v;
    logic [DATA_W-1:0] res_data;
    logic              res_ok;

    assign cap_ext   = MW'(r_cap);
    assign cap_eff   = (cap_ext > DISK_EXT) ? CAP_W'(DISK_EXT) : r_cap;
    assign pos_plus8 = {1'b0, r_pos} + (POS_W + 1)'(WORD_BYTES);
    assign data_ok   = r_present && (pos_plus8 <= {1'b0, cap_eff});

    assign o_in_stall = r_busy | r_pend_valid | xfer_sts.clearing;
    assign accept     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;

    assign pos_ext   = XW'(r_pos);
    assign xfer_addr = pos_ext[AW-1:0];

    always_comb begin
        xfer_cmd.start    = 1'b0;
        xfer_cmd.is_write = i_req_type;
        n_pos             = r_pos;
        res_v             = 1'b0;
        res_data          = '0;
        res_ok            = 1'b0;
        if (accept) begin
            if (i_reg_offset == OFF_DATA && data_ok) begin
                xfer_cmd.start = 1'b1;
                n_pos          = pos_plus8[POS_W-1:0];
            end else begin
                res_v = 1'b1;
                if (i_req_type == REQ_READ) begin
                    if (i_reg_offset == OFF_POSITION) begin
                        res_data = DATA_W'(r_pos);
                        res_ok   = 1'b1;
                    end else if (i_reg_offset == OFF_CAPACITY && r_present) begin
                        res_data = DATA_W'(cap_eff);
                        res_ok   = 1'b1;
                    end
                end else if (i_reg_offset == OFF_POSITION && r_present
                             && i_write_value[DATA_W-1:POS_W] == '0
                             && i_write_value[POS_W-1:0] <= cap_eff) begin
                    n_pos  = i_write_value[POS_W-1:0];
                    res_ok = 1'b1;
                end
            end
        end
        if (xfer_sts.done) begin
            res_v    = 1'b1;
            res_data = r_job_rd ? xfer_rdata : '0;
            res_ok   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_present <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                r_cap <= i_cfg_data;
            end else if (i_cfg_index == CFG_PRESENT) begin
                r_present <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (xfer_cmd.start) begin
                r_busy <= 1'b1;
            end else if (xfer_sts.done) begin
                r_busy <= 1'b0;
            end
            if (r_pend_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (res_v) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_pend_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer_cmd.start) begin
            r_job_rd <= (i_req_type == REQ_READ);
        end
        if (r_pend_valid && out_free) begin
            r_out_data <= r_pend_data;
            r_out_ok   <= r_pend_ok;
        end else if (res_v) begin
            if (out_free) begin
                r_out_data <= res_data;
                r_out_ok   <= res_ok;
            end else begin
                r_pend_data <= res_data;
                r_pend_ok   <= res_ok;
            end
        end
    end

    mbdp_xfer #(
        .DISK_BYTES(DISK_BYTES)
    ) u_xfer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (xfer_cmd),
        .i_addr  (xfer_addr),
        .i_wdata (i_write_value),
        .o_sts   (xfer_sts),
        .o_rdata (xfer_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_access_ok = r_out_ok;
    assign o_cfg_ready = 1'b1;

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_sts.done |-> r_busy)
        else $error("transfer done without a request in flight");

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("buffered response while output register is empty");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_sts.clearing |-> (o_in_stall && !r_busy))
        else $error("request taken during store clearing");

endmodule

/* rtl/core/mbdp_xfer.sv */
// ----------------------------------------------------------------------------
// mbdp_xfer
// Byte-wide disk store with a byte-serial transfer engine and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module mbdp_xfer #(
    parameter int  DISK_BYTES = mbdp_pkg::DISK_BYTES_DEF,
    localparam int AW         = $clog2(DISK_BYTES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mbdp_pkg::t_xfer_cmd       i_cmd,
    input  logic [AW-1:0]             i_addr,
    input  logic [mbdp_pkg::DATA_W-1:0] i_wdata,
    output mbdp_pkg::t_xfer_sts       o_sts,
    output logic [mbdp_pkg::DATA_W-1:0] o_rdata
);
    import mbdp_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DISK_BYTES - 1);
    localparam logic [2:0]    LAST_BYTE = 3'(WORD_BYTES - 1);

    logic [7:0]        r_mem [DISK_BYTES];

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_rd_v;
    logic              r_rd_last, n_rd_last;
    logic              r_done, n_done;
    logic [7:0]        r_rd_q;
    logic [DATA_W-1:0] r_shift;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;
    logic              rd_en;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_rd_last = 1'b0;
        n_done    = r_rd_last;
        mem_we    = 1'b0;
        mem_wa    = r_addr;
        mem_wd    = r_shift[7:0];
        rd_en     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = 8'h00;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_addr  = i_addr;
                    n_cnt   = 3'd0;
                    n_state = i_cmd.is_write ? ST_WRITE : ST_READ;
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_BYTE) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            ST_READ: begin
                rd_en  = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_BYTE) begin
                    n_state   = ST_IDLE;
                    n_rd_last = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_cnt     <= 3'd0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_rd_v    <= rd_en;
            r_rd_last <= n_rd_last;
            r_done    <= n_done;
        end
    end

    // LSB first: write shifts bytes out the bottom, read shifts them in the top
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd.start) begin
            r_shift <= i_wdata;
        end else if (r_state == ST_WRITE) begin
            r_shift <= {8'h00, r_shift[DATA_W-1:8]};
        end else if (r_rd_v) begin
            r_shift <= {r_rd_q, r_shift[DATA_W-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_mem[r_addr];
        end
    end

    assign o_sts.clearing = (r_state == ST_CLEAR);
    assign o_sts.done     = r_done;
    assign o_rdata        = r_shift;

endmodule
